@@ hw/rtl/sdbc_pkg.sv @@
// Shared types for the descending sort and budget count block.
package sdbc_pkg;

  localparam int PRICE_W = 32;
  localparam int INDEX_W = 5;
  localparam int NEED_W  = 6;

  // One stored entry of the sorted list
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [INDEX_W-1:0] index;
  } entry_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;   // insert item at its sorted place
    logic   shf;   // shift the list one cell toward the head
    entry_t item;  // incoming entry for an insert
  } cell_ctl_t;

endpackage

@@ hw/rtl/sdbc_cell.sv @@
// One cell of the sorted insertion chain: holds one entry and its valid bit.
module sdbc_cell
  import sdbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      prev_take,
  input  logic      prev_valid,
  input  entry_t    prev_entry,
  input  logic      next_valid,
  input  entry_t    next_entry,
  output logic      take,
  output logic      valid,
  output entry_t    entry
);

  // Give up this place when empty or when the new price is at least as large
  assign take = !(valid && (entry.price > ctl.item.price));

  // Valid bit: fill from the neighbor on insert, pull from behind on shift
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins && take) begin
      valid <= prev_take ? prev_valid : 1'b1;
    end else if (ctl.shf) begin
      valid <= next_valid;
    end
  end

  // Payload follows the same moves
  always_ff @(posedge clk) begin
    if (ctl.ins && take) begin
      entry <= prev_take ? prev_entry : ctl.item;
    end else if (ctl.shf) begin
      entry <= next_entry;
    end
  end

endmodule

@@ hw/rtl/sdbc_chain.sv @@
// Row of cells that keeps the list in descending price order.
module sdbc_chain
  import sdbc_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  output logic      head_valid,
  output entry_t    head_entry
);

  logic   take  [DEPTH];
  logic   valid [DEPTH];
  entry_t entry [DEPTH];
  logic   p_take  [DEPTH];
  logic   p_valid [DEPTH];
  entry_t p_entry [DEPTH];
  logic   n_valid [DEPTH];
  entry_t n_entry [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    // Wire each cell to its neighbors; the ends see an empty neighbor
    if (k == 0) begin : g_head
      assign p_take[k]  = 1'b0;
      assign p_valid[k] = 1'b0;
      assign p_entry[k] = entry[k];
    end else begin : g_mid
      assign p_take[k]  = take[k-1];
      assign p_valid[k] = valid[k-1];
      assign p_entry[k] = entry[k-1];
    end
    if (k == DEPTH-1) begin : g_tail
      assign n_valid[k] = 1'b0;
      assign n_entry[k] = entry[k];
    end else begin : g_body
      assign n_valid[k] = valid[k+1];
      assign n_entry[k] = entry[k+1];
    end

    sdbc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .prev_take (p_take[k]),
      .prev_valid(p_valid[k]),
      .prev_entry(p_entry[k]),
      .next_valid(n_valid[k]),
      .next_entry(n_entry[k]),
      .take      (take[k]),
      .valid     (valid[k]),
      .entry     (entry[k])
    );
  end

  assign head_valid = valid[0];
  assign head_entry = entry[0];

endmodule

@@ hw/rtl/sort_desc_then_budget_count_top.sv @@
// Top level: load prices into a sorting chain, then stream them out with budget count.
//
// Channel | Direction | Handshake          | Payload
// s_*     | in        | tvalid/tready      | tdata[31:0] price, tlast last_item
// m_*     | out       | tvalid/tready      | tdata price/index/needed_count, tuser, tlast
// apb     | in        | psel/penable/pready| budget at address 0
//
// Load takes one item per cycle; each price drops into its place in the chain at once.
// After the item flagged last, n results leave one per cycle from the chain head while
// the output is not stalled, s_tready stays low meanwhile, and loading resumes on the
// cycle after the final pop. Reset is synchronous and empties the chain; budget resets
// to zero. A stalled output holds the result register and freezes the chain shift.
module sort_desc_then_budget_count_top
  import sdbc_pkg::*;
#(
  parameter int MAX_ITEMS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] price
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] sorted_price, [36:32] arrival_index,
                                 // [42:37] needed_count, [47:43] zero
  output logic [1:0]  m_tuser,   // [0] chosen, [1] found
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W = PRICE_W + CNT_W;
  localparam logic REG_BUDGET = 1'b0;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   chosen_cnt;
  logic [SUM_W-1:0]   running_sum;
  logic [PRICE_W-1:0] budget;

  cell_ctl_t ctl;
  logic      head_valid;
  entry_t    head_entry;

  logic               in_acc;
  logic               ins;
  logic               pop;
  logic               last_pop;
  logic               chosen_now;
  logic               found_now;
  logic [SUM_W-1:0]   sum_after;
  logic [CNT_W-1:0]   chosen_cnt_next;

  logic [PRICE_W-1:0] out_price;
  logic [INDEX_W-1:0] out_index;
  logic [NEED_W-1:0]  out_needed;
  logic               out_chosen;
  logic               out_found;
  logic               out_last;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUDGET) ? budget : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BUDGET)) begin
      budget <= pwdata;
    end
  end

  // Input side: insert while there is room
  assign s_tready = (state == ST_LOAD);
  assign in_acc   = s_tvalid && s_tready;
  assign ins      = in_acc && (count < CNT_W'(MAX_ITEMS));

  // Output side: pop the head when the result register is free or being read out
  assign pop      = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign last_pop = pop && (count == CNT_W'(1));

  assign ctl.ins        = ins;
  assign ctl.shf        = pop;
  assign ctl.item.price = s_tdata;
  assign ctl.item.index = INDEX_W'(count);

  sdbc_chain #(
    .DEPTH(MAX_ITEMS)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .head_valid(head_valid),
    .head_entry(head_entry)
  );

  // Prefix sum and chosen count
  assign chosen_now      = running_sum <= SUM_W'(budget);
  assign sum_after       = running_sum + SUM_W'(head_entry.price);
  assign found_now       = sum_after > SUM_W'(budget);
  assign chosen_cnt_next = chosen_cnt + CNT_W'(chosen_now);

  // Sequencer: load until the last item, then drain the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      count       <= '0;
      chosen_cnt  <= '0;
      running_sum <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (ins) begin
              count <= count + CNT_W'(1);
            end
            if (s_tlast) begin
              state       <= ST_EMIT;
              chosen_cnt  <= '0;
              running_sum <= '0;
            end
          end
        end
        ST_EMIT: begin
          if (pop) begin
            count       <= count - CNT_W'(1);
            chosen_cnt  <= chosen_cnt_next;
            running_sum <= sum_after;
            if (last_pop) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_price  <= head_entry.price;
      out_index  <= head_entry.index;
      out_chosen <= chosen_now;
      out_last   <= last_pop;
      out_found  <= last_pop && found_now;
      out_needed <= (last_pop && found_now) ? NEED_W'(chosen_cnt_next) : '0;
    end
  end

  assign m_tdata = {5'd0, out_needed, out_index, out_price};
  assign m_tuser = {out_found, out_chosen};
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  // The fill count never runs past the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("fill count above chain length");

  // While draining, the chain head holds an entry
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> head_valid)
    else $error("chain empty while results remain");

  // The final pop leaves the chain empty
  a_drained: assert property (@(posedge clk) disable iff (rst)
    last_pop |=> !head_valid)
    else $error("chain not empty after final result");

  // A count is reported only with found
  a_need_found: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (m_tdata[42:37] == '0))
    else $error("needed count without found");
`endif

endmodule
